@@ sv/kret_pkg.sv @@
// ---------------------------------------------------------------------------
// kret_pkg
// Shared types, field widths and register codes for the key report edge
// timer.
// ---------------------------------------------------------------------------
package kret_pkg;

	// field widths
	localparam int unsigned MOD_W      = 8;
	localparam int unsigned KEY_W      = 8;
	localparam int unsigned STAMP_W    = 48;
	localparam int unsigned CNT_W      = 16;
	localparam int unsigned REG_W      = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned MAX_SLOTS  = 6;

	// parameter defaults
	localparam int unsigned DEF_KEY_SLOTS     = 6;
	localparam int unsigned DEF_KEYCODE_SPACE = 256;
	localparam int unsigned DEF_STAMP_BITS    = 48;

	// register reset values
	localparam logic [REG_W-1:0] RST_START_MASK = 8'h03;
	localparam logic [REG_W-1:0] RST_START_KEY  = 8'h3B;
	localparam logic [REG_W-1:0] RST_STOP_MASK  = 8'h03;
	localparam logic [REG_W-1:0] RST_STOP_KEY   = 8'h3C;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_MASK = 2'd0,
		REG_START_KEY  = 2'd1,
		REG_STOP_MASK  = 2'd2,
		REG_STOP_KEY   = 2'd3
	} cfg_reg_t;

	// event kinds
	typedef enum logic {
		EV_PRESS   = 1'b0,
		EV_RELEASE = 1'b1
	} ev_kind_t;

	// one timing event as held in the result buffers
	typedef struct packed {
		ev_kind_t           kind;
		logic [KEY_W-1:0]   key;
		logic [STAMP_W-1:0] interval;
		logic               rec;
		logic [CNT_W-1:0]   count;
	} event_t;

endpackage

@@ sv/kret_report_if.sv @@
// ---------------------------------------------------------------------------
// kret_report_if
// Valid/ready channel carrying one keyboard boot report with its timestamp.
// ---------------------------------------------------------------------------
interface kret_report_if;
	logic                         valid;
	logic                         ready;
	logic [kret_pkg::MOD_W-1:0]   mod_bits;
	logic [kret_pkg::KEY_W-1:0]   slot_a;
	logic [kret_pkg::KEY_W-1:0]   slot_b;
	logic [kret_pkg::KEY_W-1:0]   slot_c;
	logic [kret_pkg::KEY_W-1:0]   slot_d;
	logic [kret_pkg::KEY_W-1:0]   slot_e;
	logic [kret_pkg::KEY_W-1:0]   slot_f;
	logic [kret_pkg::STAMP_W-1:0] stamp_us;

	modport source (output valid, mod_bits, slot_a, slot_b, slot_c, slot_d, slot_e,
		slot_f, stamp_us, input ready);
	modport sink (input valid, mod_bits, slot_a, slot_b, slot_c, slot_d, slot_e,
		slot_f, stamp_us, output ready);
endinterface

@@ sv/kret_event_if.sv @@
// ---------------------------------------------------------------------------
// kret_event_if
// Valid/ready channel carrying one key press or release timing event.
// ---------------------------------------------------------------------------
interface kret_event_if;
	logic                         valid;
	logic                         ready;
	logic                         event_kind;
	logic [kret_pkg::KEY_W-1:0]   key_id;
	logic [kret_pkg::STAMP_W-1:0] interval_us;
	logic                         recording_on;
	logic [kret_pkg::CNT_W-1:0]   samples_seen;
	logic                         last_of_run;

	modport source (output valid, event_kind, key_id, interval_us, recording_on,
		samples_seen, last_of_run, input ready);
	modport sink (input valid, event_kind, key_id, interval_us, recording_on,
		samples_seen, last_of_run, output ready);
endinterface

@@ sv/key_report_edge_timer.sv @@
// ---------------------------------------------------------------------------
// key_report_edge_timer
// Turns keyboard boot reports into key press and release events with flight
// and hold times, and tracks a chord-controlled recording flag and count.
// ---------------------------------------------------------------------------
// Each accepted report is compared against the held-key map by sweeping all
// KEYCODE_SPACE keycodes in ascending order, one keycode per cycle while the
// result side does not stall, through a press-time memory with a single
// registered read port. A new report is taken only in idle, once the sweep,
// drain and flush of the report before it are done. The sweep holds while a
// new event finds both the pending slot and the output register full because
// the result side stalls. Events leave in keycode order; the final event of
// a report has last_of_run set, and a report that changes no key yields no
// events. A press reports the time since the most recent release (0 before
// any release), a release reports the time since that key's press. The
// held-key map is cleared at reset; no clearing pass is needed.
module key_report_edge_timer #(
	parameter int unsigned KEY_SLOTS     = kret_pkg::DEF_KEY_SLOTS,
	parameter int unsigned KEYCODE_SPACE = kret_pkg::DEF_KEYCODE_SPACE,
	parameter int unsigned STAMP_BITS    = kret_pkg::DEF_STAMP_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [kret_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kret_pkg::REG_W-1:0]     cfg_wdata,
	kret_report_if.sink                    report,
	kret_event_if.source                   result
);

	localparam int unsigned NSLOT = (KEY_SLOTS < kret_pkg::MAX_SLOTS) ?
		KEY_SLOTS : kret_pkg::MAX_SLOTS;
	localparam int unsigned SW = (STAMP_BITS < kret_pkg::STAMP_W) ?
		STAMP_BITS : kret_pkg::STAMP_W;
	localparam int unsigned KW = $clog2(KEYCODE_SPACE);
	localparam logic [KW-1:0] LAST_IDX = KW'(KEYCODE_SPACE - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_FLUSH} state_t;

	state_t                          state_q;
	logic [KW-1:0]                   idx_q;
	logic                            v_s1;
	logic [KW-1:0]                   idx_s1;
	logic [SW-1:0]                   rd_stamp_s1;
	logic [KEYCODE_SPACE-1:0]        held_q;
	logic [SW-1:0]                   last_rel_q;
	logic                            rec_q;
	logic [kret_pkg::CNT_W-1:0]      cnt_q;
	logic                            pend_v_q;
	kret_pkg::event_t                pend_q;
	logic                            out_v_q;
	kret_pkg::event_t                out_q;
	logic                            out_last_q;
	logic [kret_pkg::REG_W-1:0]      start_mask_q;
	logic [kret_pkg::REG_W-1:0]      start_key_q;
	logic [kret_pkg::REG_W-1:0]      stop_mask_q;
	logic [kret_pkg::REG_W-1:0]      stop_key_q;
	logic [kret_pkg::MOD_W-1:0]      mods_q;
	logic [kret_pkg::KEY_W-1:0]      slot_q [NSLOT];
	logic [SW-1:0]                   stamp_q;

	logic [SW-1:0]                   stamp_mem [KEYCODE_SPACE];

	logic [kret_pkg::KEY_W-1:0]      slots_in [kret_pkg::MAX_SLOTS];
	logic                            in_xfer;
	logic [kret_pkg::KEY_W-1:0]      key_s1;
	logic                            now_s1;
	logic                            held_s1;
	logic                            press;
	logic                            rel;
	logic                            ev;
	logic                            out_free;
	logic                            ev_ok;
	logic                            commit;
	logic                            adv;
	logic                            mv_pend;
	logic                            flush_mv;
	logic [KW-1:0]                   rd_addr;
	logic                            start_hit;
	logic                            stop_hit;
	logic                            rec_nx;
	logic [kret_pkg::CNT_W-1:0]      cnt_nx;
	logic [SW-1:0]                   flight;
	logic [SW-1:0]                   hold;
	kret_pkg::event_t                ev_d;

	// report slots in order
	assign slots_in[0] = report.slot_a;
	assign slots_in[1] = report.slot_b;
	assign slots_in[2] = report.slot_c;
	assign slots_in[3] = report.slot_d;
	assign slots_in[4] = report.slot_e;
	assign slots_in[5] = report.slot_f;

	assign report.ready = (state_q == ST_IDLE);
	assign in_xfer      = report.valid && report.ready;

	// stage 1: is this keycode in the new report
	assign key_s1 = kret_pkg::KEY_W'(idx_s1);
	always_comb begin
		now_s1 = 1'b0;
		for (int j = 0; j < NSLOT; j++) begin
			if (slot_q[j] != '0 && slot_q[j] == key_s1) begin
				now_s1 = 1'b1;
			end
		end
	end

	assign held_s1 = held_q[idx_s1];
	assign press   = v_s1 && now_s1 && !held_s1;
	assign rel     = v_s1 && !now_s1 && held_s1;
	assign ev      = press || rel;

	// event buffering: pending slot in front of the output register
	assign out_free = !out_v_q || result.ready;
	assign ev_ok    = !pend_v_q || out_free;
	assign commit   = ev && ev_ok;
	assign adv      = !ev || ev_ok;
	assign mv_pend  = commit && pend_v_q;
	assign flush_mv = (state_q == ST_FLUSH) && pend_v_q && out_free;

	// re-read the stalled entry so its data stays in the read register
	assign rd_addr = adv ? idx_q : idx_s1;

	// interval arithmetic
	assign flight = (last_rel_q != '0) ? (stamp_q - last_rel_q) : '0;
	assign hold   = stamp_q - rd_stamp_s1;

	// recording chords and sample count
	assign start_hit = ((mods_q & start_mask_q) == start_mask_q) && (key_s1 == start_key_q);
	assign stop_hit  = ((mods_q & stop_mask_q) == stop_mask_q) && (key_s1 == stop_key_q);
	always_comb begin
		cnt_nx = cnt_q;
		rec_nx = rec_q;
		if (press) begin
			if (rec_q && cnt_q != '1) begin
				cnt_nx = cnt_q + 1'b1;
			end
			priority if (start_hit) begin
				rec_nx = 1'b1;
			end else if (stop_hit) begin
				rec_nx = 1'b0;
			end else begin
				rec_nx = rec_q;
			end
		end
	end

	// event built at stage 1
	always_comb begin
		ev_d.kind     = press ? kret_pkg::EV_PRESS : kret_pkg::EV_RELEASE;
		ev_d.key      = key_s1;
		ev_d.interval = kret_pkg::STAMP_W'(press ? flight : hold);
		ev_d.rec      = rec_nx;
		ev_d.count    = cnt_nx;
	end

	// press-time memory
	always_ff @(posedge clk) begin
		if (press && ev_ok) begin
			stamp_mem[idx_s1] <= stamp_q;
		end
		rd_stamp_s1 <= stamp_mem[rd_addr];
	end

	// sequencer, key state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			held_q       <= '0;
			last_rel_q   <= '0;
			rec_q        <= 1'b0;
			cnt_q        <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
			start_mask_q <= kret_pkg::RST_START_MASK;
			start_key_q  <= kret_pkg::RST_START_KEY;
			stop_mask_q  <= kret_pkg::RST_STOP_MASK;
			stop_key_q   <= kret_pkg::RST_STOP_KEY;
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					kret_pkg::REG_START_MASK: start_mask_q <= cfg_wdata;
					kret_pkg::REG_START_KEY:  start_key_q  <= cfg_wdata;
					kret_pkg::REG_STOP_MASK:  stop_mask_q  <= cfg_wdata;
					kret_pkg::REG_STOP_KEY:   stop_key_q   <= cfg_wdata;
				endcase
			end

			// sweep control
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						idx_q   <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					if (adv) begin
						v_s1 <= 1'b1;
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DRAIN;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (adv) begin
						v_s1    <= 1'b0;
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
			endcase

			// key state update on a committed event
			if (commit) begin
				held_q[idx_s1] <= press;
				rec_q          <= rec_nx;
				cnt_q          <= cnt_nx;
				if (rel) begin
					last_rel_q <= stamp_q;
				end
			end

			// pending slot
			if (commit) begin
				pend_v_q <= 1'b1;
			end else if (flush_mv) begin
				pend_v_q <= 1'b0;
			end

			// output register
			if (mv_pend || flush_mv) begin
				out_v_q <= 1'b1;
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			mods_q  <= report.mod_bits;
			stamp_q <= report.stamp_us[SW-1:0];
			for (int j = 0; j < NSLOT; j++) begin
				slot_q[j] <= slots_in[j];
			end
		end
		if (adv) begin
			idx_s1 <= idx_q;
		end
		if (commit) begin
			pend_q <= ev_d;
		end
		if (mv_pend || flush_mv) begin
			out_q      <= pend_q;
			out_last_q <= flush_mv;
		end
	end

	// result channel
	assign result.valid        = out_v_q;
	assign result.event_kind   = out_q.kind;
	assign result.key_id       = out_q.key;
	assign result.interval_us  = out_q.interval;
	assign result.recording_on = out_q.rec;
	assign result.samples_seen = out_q.count;
	assign result.last_of_run  = out_last_q;

endmodule
